>>> hw/rtl/mru_hl_pkg.sv
// Shared constants and types for the most-recently-used history list.
package mru_hl_pkg;

	localparam int MAX_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF  = 16;

	localparam int ITEM_W  = 16;
	localparam int INDEX_W = 4;
	localparam int LEN_W   = 5;
	localparam int CAP_W   = 5;
	localparam int CMD_W   = 2;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

endpackage

>>> hw/rtl/mru_hl_ram.sv
// Single-port-write, single-port-read entry store with a registered read.
module mru_hl_ram #(
	parameter int MAX_DEPTH = mru_hl_pkg::MAX_DEPTH_DEF,
	parameter int ID_WIDTH  = mru_hl_pkg::ID_WIDTH_DEF,
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [ID_WIDTH-1:0] wr_data,
	input  logic [AW-1:0]       rd_addr,
	output logic [ID_WIDTH-1:0] rd_data
);

	logic [ID_WIDTH-1:0] mem [MAX_DEPTH];
	logic [ID_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/mru_history_list_top.sv
// Move-to-front history list: command sequencer around the entry store.
//
// Input beats on s_axis carry one command (add, remove, clear, read by index)
// in tuser and the item id and read index in tdata. Every input beat yields
// exactly one output beat on m_axis: the read entry and its valid flag, the
// list length after the command and whether the list changed.
// The capacity register is written through cfg_valid/cfg_data; the user must
// write it only while the block is idle, the block itself does not enforce
// this. Zero acts as one, values above MAX_DEPTH act as MAX_DEPTH.
// The entries sit in one memory with one read and one write port: the search
// reads one entry per cycle, and the move-to-front or close-up shift copies
// one entry per cycle through that same port pair. One command is worked at
// a time; the next beat is taken as soon as the sequencer is back at rest,
// even if the previous result still waits in the output register.
// Reset empties the list and loads a capacity of 10. A stalled receiver
// holds the result; a further result waits until the output slot frees.
module mru_history_list_top #(
	parameter int MAX_DEPTH = mru_hl_pkg::MAX_DEPTH_DEF,
	parameter int ID_WIDTH  = mru_hl_pkg::ID_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// item_id [15:0], read_index [19:16], zero [23:20]
	input  logic [mru_hl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// cmd [1:0]
	input  logic [mru_hl_pkg::CMD_W-1:0]        s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// read_item [15:0], list_length [20:16], changed [21], zero [23:22]
	output logic [mru_hl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// read_valid [0]
	output logic                                m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mru_hl_pkg::CAP_W-1:0]        cfg_data
);

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CW = $clog2(MAX_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_FRONT,
		ST_RDWAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [mru_hl_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0]                count_q;
	mru_hl_pkg::cmd_t             cmd_q;
	logic [ID_WIDTH-1:0]          id_q;
	logic [CW-1:0]                idx_q;
	logic [AW-1:0]                sh_src_q;
	logic [CW-1:0]                sh_left_q;

	logic                         cmp_vld_s1;
	logic [AW-1:0]                cmp_idx_s1;
	logic                         wr_pend_s1;
	logic [AW-1:0]                wr_dst_s1;

	logic [mru_hl_pkg::ITEM_W-1:0] res_item_q;
	logic                          res_rv_q;
	logic                          res_chg_q;

	logic                          m_valid_q;
	logic [mru_hl_pkg::ITEM_W-1:0] m_item_q;
	logic                          m_rv_q;
	logic [mru_hl_pkg::LEN_W-1:0]  m_len_q;
	logic                          m_chg_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ID_WIDTH-1:0]  ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [ID_WIDTH-1:0]  ram_rdata;

	logic                 in_beat;
	mru_hl_pkg::cmd_t     in_cmd;
	logic [mru_hl_pkg::INDEX_W-1:0] in_ridx;

	logic                 hit;
	logic                 can_issue;
	logic                 srch_done;
	logic                 srch_found;
	logic [AW-1:0]        srch_pos;
	logic [CW-1:0]        eff_cap;
	logic [CW-1:0]        add_n;
	logic [CW-1:0]        add_n_m1;
	logic [CW-1:0]        add_cnt;
	logic [CW-1:0]        rem_left;
	logic                 is_add;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= mru_hl_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign in_cmd        = mru_hl_pkg::cmd_t'(s_axis_tuser);
	assign in_ridx       = s_axis_tdata[19:16];
	assign is_add        = (cmd_q == mru_hl_pkg::CMD_ADD);

	// search compare runs in the cycle after the issued read
	always_comb begin
		hit        = cmp_vld_s1 && (ram_rdata == id_q);
		can_issue  = (idx_q < count_q);
		srch_done  = hit || !can_issue;
		srch_found = hit;
		srch_pos   = cmp_idx_s1;
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (32'(cap_q) > MAX_DEPTH) begin
			eff_cap = CW'(MAX_DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end

		if (srch_found) begin
			add_n = CW'(srch_pos);
		end else if (32'(count_q) > MAX_DEPTH - 1) begin
			add_n = CW'(MAX_DEPTH - 1);
		end else begin
			add_n = count_q;
		end
		add_n_m1 = add_n - CW'(1);

		if (srch_found) begin
			add_cnt = count_q;
		end else if (32'(count_q) < MAX_DEPTH) begin
			add_cnt = count_q + CW'(1);
		end else begin
			add_cnt = count_q;
		end
		if (add_cnt > eff_cap) begin
			add_cnt = eff_cap;
		end

		rem_left = count_q - CW'(srch_pos) - CW'(1);
	end

	always_comb begin
		case (state_q)
			ST_IDLE:   ram_raddr = AW'(in_ridx);
			ST_SEARCH: ram_raddr = idx_q[AW-1:0];
			ST_SHIFT:  ram_raddr = sh_src_q;
			default:   ram_raddr = '0;
		endcase

		ram_we    = 1'b0;
		ram_waddr = wr_dst_s1;
		ram_wdata = ram_rdata;
		if (state_q == ST_SHIFT) begin
			ram_we = wr_pend_s1;
		end else if (state_q == ST_FRONT) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = id_q;
		end
	end

	mru_hl_ram #(
		.MAX_DEPTH (MAX_DEPTH),
		.ID_WIDTH  (ID_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			cmp_vld_s1 <= 1'b0;
			wr_pend_s1 <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			// the finish state reloads the slot itself
			if (m_valid_q && m_axis_tready && state_q != ST_FINISH) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						cmd_q      <= in_cmd;
						id_q       <= ID_WIDTH'(s_axis_tdata[15:0]);
						res_item_q <= '0;
						res_rv_q   <= 1'b0;
						res_chg_q  <= (in_cmd == mru_hl_pkg::CMD_CLEAR) && (count_q != '0);
						idx_q      <= '0;
						cmp_vld_s1 <= 1'b0;
						case (in_cmd)
							mru_hl_pkg::CMD_CLEAR: begin
								count_q   <= '0;
								state_q   <= ST_FINISH;
							end
							mru_hl_pkg::CMD_READ: begin
								if (32'(in_ridx) < 32'(count_q)) begin
									state_q <= ST_RDWAIT;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							default: begin
								state_q <= ST_SEARCH;
							end
						endcase
					end
				end

				ST_SEARCH: begin
					if (srch_done) begin
						cmp_vld_s1 <= 1'b0;
						if (is_add) begin
							if (srch_found && srch_pos == '0) begin
								state_q <= ST_FINISH;
							end else begin
								sh_left_q <= add_n;
								sh_src_q  <= add_n_m1[AW-1:0];
								count_q   <= add_cnt;
								res_chg_q <= 1'b1;
								state_q   <= ST_SHIFT;
							end
						end else begin
							if (!srch_found) begin
								state_q <= ST_FINISH;
							end else begin
								sh_left_q <= rem_left;
								sh_src_q  <= srch_pos + AW'(1);
								count_q   <= count_q - CW'(1);
								res_chg_q <= 1'b1;
								state_q   <= ST_SHIFT;
							end
						end
					end else begin
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= idx_q[AW-1:0];
						idx_q      <= idx_q + CW'(1);
					end
				end

				// read one entry, write it one place over on the next cycle
				ST_SHIFT: begin
					if (sh_left_q != '0) begin
						wr_pend_s1 <= 1'b1;
						if (is_add) begin
							wr_dst_s1 <= sh_src_q + AW'(1);
							sh_src_q  <= sh_src_q - AW'(1);
						end else begin
							wr_dst_s1 <= sh_src_q - AW'(1);
							sh_src_q  <= sh_src_q + AW'(1);
						end
						sh_left_q <= sh_left_q - CW'(1);
					end else begin
						wr_pend_s1 <= 1'b0;
						state_q    <= is_add ? ST_FRONT : ST_FINISH;
					end
				end

				ST_FRONT: begin
					state_q <= ST_FINISH;
				end

				ST_RDWAIT: begin
					res_item_q <= mru_hl_pkg::ITEM_W'(ram_rdata);
					res_rv_q   <= 1'b1;
					state_q    <= ST_FINISH;
				end

				ST_FINISH: begin
					// hold until the output slot is free
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_item_q  <= res_item_q;
						m_rv_q    <= res_rv_q;
						m_len_q   <= mru_hl_pkg::LEN_W'(count_q);
						m_chg_q   <= res_chg_q;
						state_q   <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_chg_q, m_len_q, m_item_q};
	assign m_axis_tuser  = m_rv_q;

endmodule
